// ===== hw/rtl/rtc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the RTD code to temperature block.
// Holds the payload and sideband types and the fixed-point constants; no dependencies.
package rtc_pkg;

	typedef struct packed {
		logic [15:0] rtd_word;
		logic [7:0]  fault_byte;
	} item_t;

	typedef struct packed {
		logic signed [18:0] temperature;
		logic               fault_flag;
		logic [7:0]         fault_code;
		logic               domain_error;
	} result_t;

	localparam int Y_FRAC = 24;
	localparam int XQ_W   = Y_FRAC + 3;
	localparam int YM_W   = Y_FRAC + 3;
	localparam int D_W    = 42;
	localparam int ROOT_W = 21;
	localparam int RS_W   = 22;
	localparam int RS_MIN_BITS = 20;

	// Sideband that travels with every word down the cell chain.
	typedef struct packed {
		logic              valid;
		logic              fault;
		logic              dom;
		logic [7:0]        fcode;
		logic              yneg;
		logic [YM_W-1:0]   ym;
	} side_t;

	localparam logic [20:0]    COEF_A_Q28  = 21'd1049126;
	localparam logic [37:0]    COEF_4B_Q56 = 38'd166453042228;
	localparam logic [D_W-1:0] COEF_A_SQ   = 42'd1100665363876;
	localparam logic [XQ_W-1:0] ONE_Q24    = 27'd16777216;

	localparam logic signed [18:0] TEMP_MAX = 19'sd262143;
	localparam logic signed [18:0] TEMP_MIN = -19'sd262144;
	localparam int TEMP_LIMIT = 262144;

	localparam logic REG_REFERENCE = 1'b0;
	localparam logic REG_NOMINAL   = 1'b1;

endpackage

// ===== hw/rtl/rtd_code_to_temperature_top.sv =====
`timescale 1ns / 1ps
// RTD code to temperature converter, top level.
// Uses rtc_pkg, rtc_div_cell and rtc_sqrt_cell.
//
// A word (RTD data register and fault status byte) is taken at a rising edge
// with start high; busy is always low, so a new word may follow every cycle.
// Each word yields one result on the result port, marked by done for exactly
// one cycle; the receiver cannot stall it, so nothing is held back.
// On its way to the result port a word passes registers at entry, multiply
// and range check, a chain of 27 division cells for the resistance ratio,
// two multiply stages for the discriminant, 21 square root cells, the root
// sum, 12 + TEMP_FRAC_BITS division cells for the temperature and the output
// register. Throughput is one word per cycle.
// The user writes the two registers (reference_ohms at 0x0, nominal_ohms at
// 0x4) over the APB port only while no word is in flight; the block itself
// does not enforce this, and pready is always high.
// Reset clears the pipeline and loads 400 and 100 ohms.
module rtd_code_to_temperature_top
	import rtc_pkg::*;
#(
	parameter int CODE_BITS      = 15,
	parameter int TEMP_FRAC_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        done,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int NUM_W = CODE_BITS + 14;
	localparam int DEN_W = CODE_BITS + 12;
	localparam int RW1   = DEN_W + 3;
	localparam int MAG_W = YM_W + 5 + TEMP_FRAC_BITS;
	localparam int QW2   = MAG_W - RS_MIN_BITS;
	localparam int RW2   = RS_W + QW2;
	localparam int CMP_W = (QW2 > 19 ? QW2 : 19) + 1;
	localparam int SIDE_W = $bits(side_t);

	logic [13:0] ref_q;
	logic [11:0] nom_q;

	// Configuration port.
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= 14'd400;
			nom_q <= 12'd100;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_REFERENCE: ref_q <= pwdata[13:0];
				REG_NOMINAL:   nom_q <= pwdata[11:0];
				default:       ref_q <= ref_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_REFERENCE: prdata = {18'd0, ref_q};
			REG_NOMINAL:   prdata = {20'd0, nom_q};
			default:       prdata = '0;
		endcase
	end

	// Entry register.
	item_t item_s0;
	logic  v_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else begin
			v_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s0 <= item;
	end

	// Stage 1: code times reference resistance.
	logic [CODE_BITS-1:0] code;
	logic [NUM_W-1:0]     num_s1;
	side_t                side_s1;
	side_t                side_n1;

	assign code = CODE_BITS'(item_s0.rtd_word[15:1]);

	always_comb begin
		side_n1       = '0;
		side_n1.valid = v_s0;
		side_n1.fault = item_s0.rtd_word[0];
		side_n1.fcode = item_s0.rtd_word[0] ? item_s0.fault_byte : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= side_n1;
		end
	end

	always_ff @(posedge clk) begin
		num_s1 <= NUM_W'(code) * NUM_W'(ref_q);
	end

	// Stage 2: range check and divider setup.
	logic [DEN_W-1:0] den;
	logic             over;
	logic [RW1-1:0]   r1_s2;
	logic [RW1-1:0]   d1_s2;
	side_t            side_s2;
	side_t            side_n2;

	assign den  = {nom_q, {CODE_BITS{1'b0}}};
	assign over = (nom_q == 12'd0) || ((CODE_BITS + 15)'(num_s1) >= {den, 3'b000});

	always_comb begin
		side_n2     = side_s1;
		side_n2.dom = !side_s1.fault && over;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= side_n2;
		end
	end

	always_ff @(posedge clk) begin
		r1_s2 <= RW1'(num_s1);
		d1_s2 <= RW1'({den, 2'b00});
	end

	// Ratio division chain: one quotient bit of x in Q24 per cell.
	logic [RW1-1:0]    r1 [0:XQ_W];
	logic [RW1-1:0]    d1 [0:XQ_W];
	logic [XQ_W-1:0]   q1 [0:XQ_W];
	logic [SIDE_W-1:0] sd1 [0:XQ_W];

	assign r1[0]  = r1_s2;
	assign d1[0]  = d1_s2;
	assign q1[0]  = '0;
	assign sd1[0] = side_s2;

	for (genvar i = 0; i < XQ_W; i++) begin : g_div1
		rtc_div_cell #(.RW(RW1), .QW(XQ_W), .SIDE_W(SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.r_in    (r1[i]),
			.d_in    (d1[i]),
			.q_in    (q1[i]),
			.side_in (sd1[i]),
			.r_q     (r1[i+1]),
			.d_q     (d1[i+1]),
			.q_q     (q1[i+1]),
			.side_q  (sd1[i+1])
		);
	end

	// Multiply stage 1: y = 1 - x as sign and magnitude, partial products.
	logic [XQ_W-1:0] xq;
	logic            yneg;
	logic [YM_W-1:0] ym;
	logic [61:0]     pfrac_m1;
	logic [40:0]     pint_m1;
	side_t           side_m1;
	side_t           side_nm1;

	assign xq   = q1[XQ_W];
	assign yneg = xq > ONE_Q24;
	assign ym   = yneg ? xq - ONE_Q24 : ONE_Q24 - xq;

	always_comb begin
		side_nm1      = side_t'(sd1[XQ_W]);
		side_nm1.yneg = yneg;
		side_nm1.ym   = ym;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_m1 <= '0;
		end else begin
			side_m1 <= side_nm1;
		end
	end

	always_ff @(posedge clk) begin
		pfrac_m1 <= 62'(COEF_4B_Q56) * 62'(ym[Y_FRAC-1:0]);
		pint_m1  <= 41'(COEF_4B_Q56) * 41'(ym[YM_W-1:Y_FRAC]);
	end

	// Multiply stage 2: discriminant.
	logic [D_W-1:0] term;
	logic           neg_disc;
	logic [D_W-1:0] d_m2;
	side_t          side_m2;
	side_t          side_nm2;

	assign term     = D_W'(pint_m1) + D_W'(pfrac_m1 >> Y_FRAC);
	assign neg_disc = side_m1.yneg && (term > COEF_A_SQ);

	always_comb begin
		side_nm2     = side_m1;
		side_nm2.dom = side_m1.dom || (!side_m1.fault && neg_disc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_m2 <= '0;
		end else begin
			side_m2 <= side_nm2;
		end
	end

	always_ff @(posedge clk) begin
		d_m2 <= side_m1.yneg ? COEF_A_SQ - term : COEF_A_SQ + term;
	end

	// Square root chain: one root bit per cell, most significant first.
	logic [D_W-1:0]    rem [0:ROOT_W];
	logic [D_W-1:0]    rt  [0:ROOT_W];
	logic [SIDE_W-1:0] sd2 [0:ROOT_W];

	assign rem[0] = d_m2;
	assign rt[0]  = '0;
	assign sd2[0] = side_m2;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		rtc_sqrt_cell #(.VW(D_W), .BITPOS(ROOT_W - 1 - i), .SIDE_W(SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rem_in  (rem[i]),
			.root_in (rt[i]),
			.side_in (sd2[i]),
			.rem_q   (rem[i+1]),
			.root_q  (rt[i+1]),
			.side_q  (sd2[i+1])
		);
	end

	// Root sum stage: set up |y| * 2^(5+TF) + (A+s)/2 over A+s.
	logic [RS_W-1:0]  rs;
	logic [MAG_W-1:0] mag;
	side_t            side_r;
	side_t            side_nr;
	logic [RW2-1:0]   r2_r;
	logic [RW2-1:0]   d2_r;

	assign side_nr = side_t'(sd2[ROOT_W]);
	assign rs      = RS_W'(COEF_A_Q28) + RS_W'(rt[ROOT_W][ROOT_W-1:0]);
	assign mag     = MAG_W'(side_nr.ym) << (5 + TEMP_FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_r <= '0;
		end else begin
			side_r <= side_nr;
		end
	end

	always_ff @(posedge clk) begin
		r2_r <= RW2'(mag) + RW2'(rs >> 1);
		d2_r <= RW2'(rs) << (QW2 - 1);
	end

	// Temperature division chain.
	logic [RW2-1:0]    r2  [0:QW2];
	logic [RW2-1:0]    d2  [0:QW2];
	logic [QW2-1:0]    q2  [0:QW2];
	logic [SIDE_W-1:0] sd3 [0:QW2];

	assign r2[0]  = r2_r;
	assign d2[0]  = d2_r;
	assign q2[0]  = '0;
	assign sd3[0] = side_r;

	for (genvar i = 0; i < QW2; i++) begin : g_div2
		rtc_div_cell #(.RW(RW2), .QW(QW2), .SIDE_W(SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.r_in    (r2[i]),
			.d_in    (d2[i]),
			.q_in    (q2[i]),
			.side_in (sd3[i]),
			.r_q     (r2[i+1]),
			.d_q     (d2[i+1]),
			.q_q     (q2[i+1]),
			.side_q  (sd3[i+1])
		);
	end

	// Output stage: sign, saturation and special cases.
	side_t          side_o;
	logic [CMP_W-1:0] q_ext;
	result_t        res_n;
	result_t        result_q;
	logic           done_q;

	assign side_o = side_t'(sd3[QW2]);
	assign q_ext  = CMP_W'(q2[QW2]);

	always_comb begin
		res_n              = '0;
		res_n.fault_flag   = side_o.fault;
		res_n.fault_code   = side_o.fcode;
		if (side_o.fault) begin
			res_n.temperature = '0;
		end else if (side_o.dom) begin
			res_n.temperature  = TEMP_MAX;
			res_n.domain_error = 1'b1;
		end else if (side_o.yneg) begin
			if (q_ext >= CMP_W'(TEMP_LIMIT)) begin
				res_n.temperature  = TEMP_MAX;
				res_n.domain_error = 1'b1;
			end else begin
				res_n.temperature = 19'(q2[QW2]);
			end
		end else begin
			// The magnitude is clamped before negation, so a reading colder than
			// the range lands on the coldest value without raising the flag.
			if (q_ext > CMP_W'(TEMP_LIMIT)) begin
				res_n.temperature = TEMP_MIN;
			end else begin
				res_n.temperature = -19'(q2[QW2]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_o.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_n;
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

// ===== hw/rtl/rtc_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division cell: produces one quotient bit per word and hands on.
// Depends on nothing but its parameters.
module rtc_div_cell #(
	parameter int RW     = 20,
	parameter int QW     = 8,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RW-1:0]     r_in,
	input  logic [RW-1:0]     d_in,
	input  logic [QW-1:0]     q_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [RW-1:0]     r_q,
	output logic [RW-1:0]     d_q,
	output logic [QW-1:0]     q_q,
	output logic [SIDE_W-1:0] side_q
);
	logic          ge;
	logic [RW-1:0] diff;

	assign ge   = r_in >= d_in;
	assign diff = ge ? r_in - d_in : r_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	// The remainder stays below the divisor, so doubling it never overflows.
	always_ff @(posedge clk) begin
		r_q <= {diff[RW-2:0], 1'b0};
		d_q <= d_in;
		q_q <= {q_in[QW-2:0], ge};
	end
endmodule

// ===== hw/rtl/rtc_sqrt_cell.sv =====
`timescale 1ns / 1ps
// One digit-by-digit square root cell: decides one root bit per word.
// Depends on nothing but its parameters.
module rtc_sqrt_cell #(
	parameter int VW     = 42,
	parameter int BITPOS = 0,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [VW-1:0]     rem_in,
	input  logic [VW-1:0]     root_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [VW-1:0]     rem_q,
	output logic [VW-1:0]     root_q,
	output logic [SIDE_W-1:0] side_q
);
	logic [VW-1:0] trial;
	logic          take;

	// (r + 2^b)^2 - r^2, where r holds only bits above b.
	assign trial = (root_in << (BITPOS + 1)) | (VW'(1) << (2 * BITPOS));
	assign take  = trial <= rem_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= '0;
		end else begin
			side_q <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_q  <= take ? rem_in - trial : rem_in;
		root_q <= take ? (root_in | (VW'(1) << BITPOS)) : root_in;
	end
endmodule

// ===== tb/tb_rtd_code_to_temperature_top.sv =====
`timescale 1ns / 1ps
// Testbench for the RTD code to temperature converter: random and directed words,
// results predicted in a scoreboard class and checked in order. Depends on rtc_pkg and the RTL.
module tb_rtd_code_to_temperature_top;
	import rtc_pkg::*;

	localparam longint A_Q28   = 1049126;
	localparam longint B4_Q56  = 64'd166453042228;
	localparam int     LATENCY = 75;
	localparam int     CYCLE_LIMIT = 200000;

	class temp_scoreboard;
		bit [13:0] ref_ohms;
		bit [11:0] nom_ohms;
		result_t   pending[$];
		int        errors;

		function new();
			ref_ohms = 400;
			nom_ohms = 100;
			errors = 0;
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function result_t convert(item_t it);
			result_t res;
			longint unsigned code, num, den, xq, ym, term, a2, d, rs, q;
			bit yneg;
			res = '0;
			if (it.rtd_word[0]) begin
				res.fault_flag = 1'b1;
				res.fault_code = it.fault_byte;
				return res;
			end
			code = it.rtd_word[15:1];
			num = code * ref_ohms;
			den = longint'(nom_ohms) << 15;
			if (den == 0 || num >= 8 * den) begin
				res.temperature = TEMP_MAX;
				res.domain_error = 1'b1;
				return res;
			end
			xq = ((num / den) << 24) + (((num % den) << 24) / den);
			yneg = xq > (64'd1 << 24);
			ym = yneg ? xq - (64'd1 << 24) : (64'd1 << 24) - xq;
			term = B4_Q56 * (ym >> 24) + ((B4_Q56 * (ym & 64'hFFFFFF)) >> 24);
			a2 = A_Q28 * A_Q28;
			if (yneg && term > a2) begin
				res.temperature = TEMP_MAX;
				res.domain_error = 1'b1;
				return res;
			end
			d = yneg ? a2 - term : a2 + term;
			rs = A_Q28 + isqrt(d);
			q = ((ym << 13) + rs / 2) / rs;
			if (yneg && q > 262143) begin
				res.temperature = TEMP_MAX;
				res.domain_error = 1'b1;
			end else if (!yneg && q > 262144) begin
				res.temperature = TEMP_MIN;
			end else begin
				res.temperature = yneg ? q[18:0] : -q[18:0];
			end
			return res;
		endfunction

		function void note_word(item_t it);
			pending.push_back(convert(it));
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending.size() == 0) begin
				$error("unexpected result %p", got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.temperature !== exp.temperature) begin
				$error("temperature exp %0d got %0d", exp.temperature, got.temperature);
				errors++;
			end
			if (got.fault_flag !== exp.fault_flag) begin
				$error("fault_flag exp %0d got %0d", exp.fault_flag, got.fault_flag);
				errors++;
			end
			if (got.fault_code !== exp.fault_code) begin
				$error("fault_code exp %0h got %0h", exp.fault_code, got.fault_code);
				errors++;
			end
			if (got.domain_error !== exp.domain_error) begin
				$error("domain_error exp %0d got %0d", exp.domain_error, got.domain_error);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	item_t       item = '0;
	logic        done;
	result_t     result;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	temp_scoreboard sb = new();
	int cycles = 0;
	int idle_pct = 0;

	rtd_code_to_temperature_top uut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	task automatic write_reg(logic addr_sel, logic [31:0] value);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {addr_sel, 2'b00}; pwdata <= value;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (addr_sel == REG_REFERENCE) sb.ref_ohms = value[13:0];
		else sb.nom_ohms = value[11:0];
	endtask

	// Start stays high across back-to-back words; it drops only on idle cycles.
	// The task returns at the accepting edge with start still high.
	task automatic send_word(item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		item <= it;
		do @(posedge clk); while (busy);
		sb.note_word(it);
	endtask

	// Lowers start at the edge of the last acceptance, then waits for all results.
	task automatic drain();
		start <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic item_t rand_word();
		item_t it;
		it.rtd_word = 16'($urandom);
		it.fault_byte = 8'($urandom);
		// Mostly healthy words so the conversion path is exercised.
		if ($urandom_range(9) != 0) it.rtd_word[0] = 1'b0;
		return it;
	endfunction

	task automatic send_stream(int n);
		repeat (n) send_word(rand_word());
	endtask

	initial begin
		item_t it;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed words at reset values.
		it = '{16'h0000, 8'h00}; send_word(it);
		it = '{16'hFFFE, 8'h00}; send_word(it);
		it = '{16'hFFFF, 8'hFF}; send_word(it);
		it = '{16'h0001, 8'hA5}; send_word(it);
		it = '{16'h4000, 8'h00}; send_word(it);
		it = '{16'h3FFE, 8'h5A}; send_word(it);
		it = '{16'h1000, 8'h00}; send_word(it);
		drain();
		write_reg(REG_REFERENCE, 32'hFFFFFFFF);
		write_reg(REG_NOMINAL, 32'd1);
		it = '{16'h0002, 8'h00}; send_word(it);
		it = '{16'hFFFE, 8'h00}; send_word(it);
		it = '{16'h0000, 8'h00}; send_word(it);
		drain();
		write_reg(REG_REFERENCE, 32'd1);
		write_reg(REG_NOMINAL, 32'hFFF);
		it = '{16'hFFFE, 8'h00}; send_word(it);
		it = '{16'h0002, 8'h00}; send_word(it);
		drain();
		write_reg(REG_REFERENCE, 32'd430);
		write_reg(REG_NOMINAL, 32'd100);
		it = '{16'hFFFE, 8'h00}; send_word(it);
		it = '{16'h7FFE, 8'h00}; send_word(it);
		drain();
		// Random phases with varying settings and idle rates.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: idle_pct = 18;
				1: idle_pct = 79;
				default: idle_pct = 0;
			endcase
			if (ph == 5) begin
				write_reg(REG_REFERENCE, 32'd400);
				write_reg(REG_NOMINAL, 32'd100);
			end else begin
				write_reg(REG_REFERENCE, $urandom_range(16383, 1));
				write_reg(REG_NOMINAL, $urandom_range(4095, 1));
			end
			send_stream(64);
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
